[src/htc_pkg.sv]
// Shared constants and types for the humidity/temperature calibrator.
`default_nettype none
package htc_pkg;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int RAW_WIDTH_DEF     = 16;
  localparam int VALUE_W  = 24;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int HUM_PT_W  = 8;
  localparam int TEMP_PT_W = 10;
  localparam int HUM_SHIFT  = 1;
  localparam int TEMP_SHIFT = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_P0   = 3'd0,
    REG_HUM_P1   = 3'd1,
    REG_TEMP_P0  = 3'd2,
    REG_TEMP_P1  = 3'd3,
    REG_HUM_R0   = 3'd4,
    REG_HUM_R1   = 3'd5,
    REG_TEMP_R0  = 3'd6,
    REG_TEMP_R1  = 3'd7
  } cfg_reg_t;

  // per-lane result flags handed to the merge stage
  typedef struct packed {
    logic valid;
    logic span_error;
  } lane_flags_t;
endpackage
`default_nettype wire

[src/htc_if.sv]
// Valid/ready channel interfaces for samples and results.
`default_nettype none
interface htc_in_if #(parameter int RAW_WIDTH = htc_pkg::RAW_WIDTH_DEF);
  logic valid;
  logic ready;
  logic humidity_ready;
  logic signed [RAW_WIDTH-1:0] humidity_raw;
  logic temperature_ready;
  logic signed [RAW_WIDTH-1:0] temperature_raw;
  modport source (output valid, humidity_ready, humidity_raw, temperature_ready,
                  temperature_raw, input ready);
  modport sink   (input valid, humidity_ready, humidity_raw, temperature_ready,
                  temperature_raw, output ready);
endinterface

interface htc_out_if;
  logic valid;
  logic ready;
  logic humidity_valid;
  logic signed [htc_pkg::VALUE_W-1:0] humidity_value;
  logic humidity_span_error;
  logic temperature_valid;
  logic signed [htc_pkg::VALUE_W-1:0] temperature_value;
  logic temperature_span_error;
  modport source (output valid, humidity_valid, humidity_value, humidity_span_error,
                  temperature_valid, temperature_value, temperature_span_error,
                  input ready);
  modport sink   (input valid, humidity_valid, humidity_value, humidity_span_error,
                  temperature_valid, temperature_value, temperature_span_error,
                  output ready);
endinterface
`default_nettype wire

[src/htc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
`default_nettype none
module htc_div #(
  parameter int NW = 40,
  parameter int DW = 17,
  parameter int TW = 4
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [TW-1:0] tag_in,
  output logic      [NW-1:0] quo,
  output logic      [TW-1:0] tag_out
);
  logic [NW-1:0] q_r   [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic [TW-1:0] t_r   [NW+1];

  always_comb begin
    q_r[0]   = num;
    rem_r[0] = '0;
    d_r[0]   = den;
    t_r[0]   = tag_in;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW+1:0] shifted;
    always_comb begin
      shifted = {rem_r[s], q_r[s][NW-1]};
      trial   = shifted - {2'b00, d_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[DW+1]) begin
          rem_r[s+1] <= trial[DW:0];
          q_r[s+1]   <= {q_r[s][NW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= shifted[DW:0];
          q_r[s+1]   <= {q_r[s][NW-2:0], 1'b0};
        end
        d_r[s+1] <= d_r[s];
        t_r[s+1] <= t_r[s];
      end
    end
  end

  assign quo     = q_r[NW];
  assign tag_out = t_r[NW];
endmodule
`default_nettype wire

[src/htc_lane.sv]
// One calibration lane: offset, scale multiply, pipelined divide, add and saturate.
`default_nettype none
module htc_lane #(
  parameter int FRACTION_BITS = htc_pkg::FRACTION_BITS_DEF,
  parameter int RAW_WIDTH     = htc_pkg::RAW_WIDTH_DEF,
  parameter int PT_W          = 8,
  parameter int SHIFT         = 1
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic                        ready_in,
  input  wire logic signed [RAW_WIDTH-1:0] raw,
  input  wire logic signed [RAW_WIDTH-1:0] r0,
  input  wire logic signed [RAW_WIDTH-1:0] r1,
  input  wire logic        [PT_W-1:0]      p0,
  input  wire logic        [PT_W-1:0]      p1,
  output htc_pkg::lane_flags_t             flags,
  output logic signed [htc_pkg::VALUE_W-1:0] value
);
  localparam int DIFF_W = RAW_WIDTH + 1;
  localparam int SPAN_W = PT_W + 1;
  localparam int UNIT   = FRACTION_BITS - SHIFT;
  localparam int PROD_W = DIFF_W + SPAN_W;
  localparam int NW     = PROD_W + UNIT;
  localparam int BASE_W = PT_W + UNIT + 1;
  localparam int SUM_W  = NW + 2;
  localparam int TW     = 3 + BASE_W;
  localparam int VW     = htc_pkg::VALUE_W;

  // stage 1: differences
  logic signed [DIFF_W-1:0] num_d_r, den_d_r;
  logic signed [SPAN_W-1:0] span_r;
  logic [PT_W-1:0]          p0_1_r;
  logic                     rdy1_r;
  // stage 2: product and magnitudes
  logic signed [PROD_W-1:0] prod_r;
  logic [DIFF_W-1:0]        den_mag_r;
  logic                     den_neg_r, rdy2_r, zero2_r;
  logic [PT_W-1:0]          p0_2_r;
  // stage 3: dividend magnitude
  logic [NW-1:0]            num_mag_r;
  logic [DIFF_W-1:0]        den3_r;
  logic [TW-1:0]            tag3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_d_r <= DIFF_W'(raw) - DIFF_W'(r0);
      den_d_r <= DIFF_W'(r1) - DIFF_W'(r0);
      span_r  <= $signed({1'b0, p1}) - $signed({1'b0, p0});
      p0_1_r  <= p0;
      rdy1_r  <= ready_in;

      prod_r    <= num_d_r * span_r;
      den_mag_r <= den_d_r[DIFF_W-1] ? DIFF_W'(-den_d_r) : den_d_r;
      den_neg_r <= den_d_r[DIFF_W-1];
      zero2_r   <= (den_d_r == '0);
      rdy2_r    <= rdy1_r;
      p0_2_r    <= p0_1_r;

      num_mag_r <= prod_r[PROD_W-1] ? NW'(-(PROD_W'(prod_r))) << UNIT
                                    : NW'(prod_r) << UNIT;
      den3_r    <= zero2_r ? DIFF_W'(1) : den_mag_r;
      tag3_r    <= {rdy2_r, zero2_r, prod_r[PROD_W-1] ^ den_neg_r,
                    BASE_W'(p0_2_r) << UNIT};
    end
  end

  logic [NW-1:0] quo;
  logic [TW-1:0] tag_q;

  htc_div #(.NW(NW), .DW(DIFF_W), .TW(TW)) u_div (
    .clk(clk), .en(en), .num(num_mag_r), .den(den3_r),
    .tag_in(tag3_r), .quo(quo), .tag_out(tag_q)
  );

  logic signed [SUM_W-1:0] sum;
  logic signed [VW-1:0]    sat;
  logic                    rdy_q, zero_q, neg_q;
  logic [BASE_W-1:0]       base_q;

  always_comb begin
    {rdy_q, zero_q, neg_q, base_q} = tag_q;
    sum = (neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo}))
          + $signed(SUM_W'(base_q));
    if (sum > $signed(SUM_W'((1 << (VW - 1)) - 1)))
      sat = VW'((1 << (VW - 1)) - 1);
    else if (sum < -$signed(SUM_W'(1 << (VW - 1))))
      sat = VW'(1 << (VW - 1));
    else
      sat = VW'(sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags.valid      <= rdy_q && !zero_q;
      flags.span_error <= rdy_q && zero_q;
      value            <= (rdy_q && !zero_q) ? sat : '0;
    end
  end
endmodule
`default_nettype wire

[src/humidity_temperature_calibrate.sv]
// Top level: config registers, two calibration lanes, valid pipeline and output merge.
//
// Usage:
//   in channel  : one sample per transfer, humidity and temperature raw counts
//                 with a ready flag each; a channel whose flag is low gives zeros.
//   out channel : one result per sample, values in signed 24-bit fixed point with
//                 FRACTION_BITS - SHIFT fraction bits per lane, plus valid and span error.
//   cfg port    : write enable, index 0..7, 16-bit data; write only when idle.
// Path: the lane input stages, the bit-per-stage divider and the lane result
//   register in each lane, then the output register.
// Throughput: one sample per cycle; whole pipeline advances when the output
//   register is empty or being taken.
// Reset clears the calibration registers, the valid pipeline and the output valid bit.
// A stalled receiver freezes the pipeline; in_ready is low while a result
//   waits untaken.
`default_nettype none
module humidity_temperature_calibrate #(
  parameter int FRACTION_BITS = htc_pkg::FRACTION_BITS_DEF,
  parameter int RAW_WIDTH     = htc_pkg::RAW_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  htc_in_if.sink                             in_ch,
  htc_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [htc_pkg::CFG_W-1:0]     cfg_data
);
  localparam int LAT = 3 + (RAW_WIDTH + 1 + htc_pkg::TEMP_PT_W + 1
                       + FRACTION_BITS - htc_pkg::TEMP_SHIFT) + 1;
  localparam int LAT_H = 3 + (RAW_WIDTH + 1 + htc_pkg::HUM_PT_W + 1
                       + FRACTION_BITS - htc_pkg::HUM_SHIFT) + 1;
  localparam int PAD = LAT - LAT_H;

  logic [htc_pkg::HUM_PT_W-1:0]  hum_p0_r, hum_p1_r;
  logic [htc_pkg::TEMP_PT_W-1:0] temp_p0_r, temp_p1_r;
  logic [RAW_WIDTH-1:0] hum_r0_r, hum_r1_r, temp_r0_r, temp_r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hum_p0_r <= '0; hum_p1_r <= '0; temp_p0_r <= '0; temp_p1_r <= '0;
      hum_r0_r <= '0; hum_r1_r <= '0; temp_r0_r <= '0; temp_r1_r <= '0;
    end else if (cfg_we) begin
      unique case (htc_pkg::cfg_reg_t'(cfg_index))
        htc_pkg::REG_HUM_P0:  hum_p0_r  <= cfg_data[htc_pkg::HUM_PT_W-1:0];
        htc_pkg::REG_HUM_P1:  hum_p1_r  <= cfg_data[htc_pkg::HUM_PT_W-1:0];
        htc_pkg::REG_TEMP_P0: temp_p0_r <= cfg_data[htc_pkg::TEMP_PT_W-1:0];
        htc_pkg::REG_TEMP_P1: temp_p1_r <= cfg_data[htc_pkg::TEMP_PT_W-1:0];
        htc_pkg::REG_HUM_R0:  hum_r0_r  <= RAW_WIDTH'(cfg_data);
        htc_pkg::REG_HUM_R1:  hum_r1_r  <= RAW_WIDTH'(cfg_data);
        htc_pkg::REG_TEMP_R0: temp_r0_r <= RAW_WIDTH'(cfg_data);
        htc_pkg::REG_TEMP_R1: temp_r1_r <= RAW_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic en;
  logic [LAT-1:0] vpipe_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vpipe_r <= '0;
    else if (en) vpipe_r <= {vpipe_r[LAT-2:0], in_ch.valid};
  end

  // humidity inputs are delayed by PAD so both lanes line up; with the package constants the lanes are equally long
  logic                 hum_rdy_d [PAD+1];
  logic [RAW_WIDTH-1:0] hum_raw_d [PAD+1];
  assign hum_rdy_d[0] = in_ch.humidity_ready;
  assign hum_raw_d[0] = in_ch.humidity_raw;
  for (genvar i = 0; i < PAD; i++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        hum_rdy_d[i+1] <= hum_rdy_d[i];
        hum_raw_d[i+1] <= hum_raw_d[i];
      end
    end
  end

  htc_pkg::lane_flags_t hum_f, temp_f;
  logic signed [htc_pkg::VALUE_W-1:0] hum_v, temp_v;

  htc_lane #(.FRACTION_BITS(FRACTION_BITS), .RAW_WIDTH(RAW_WIDTH),
             .PT_W(htc_pkg::HUM_PT_W), .SHIFT(htc_pkg::HUM_SHIFT)) u_hum (
    .clk(clk), .en(en), .ready_in(hum_rdy_d[PAD]), .raw(hum_raw_d[PAD]),
    .r0(hum_r0_r), .r1(hum_r1_r), .p0(hum_p0_r), .p1(hum_p1_r),
    .flags(hum_f), .value(hum_v)
  );

  htc_lane #(.FRACTION_BITS(FRACTION_BITS), .RAW_WIDTH(RAW_WIDTH),
             .PT_W(htc_pkg::TEMP_PT_W), .SHIFT(htc_pkg::TEMP_SHIFT)) u_temp (
    .clk(clk), .en(en), .ready_in(in_ch.temperature_ready),
    .raw(in_ch.temperature_raw), .r0(temp_r0_r), .r1(temp_r1_r),
    .p0(temp_p0_r), .p1(temp_p1_r), .flags(temp_f), .value(temp_v)
  );

  // merge stage: output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vpipe_r[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.humidity_valid         <= hum_f.valid;
      out_ch.humidity_value         <= hum_v;
      out_ch.humidity_span_error    <= hum_f.span_error;
      out_ch.temperature_valid      <= temp_f.valid;
      out_ch.temperature_value      <= temp_v;
      out_ch.temperature_span_error <= temp_f.span_error;
    end
  end

  assign out_ch.valid = out_valid_r;
endmodule
`default_nettype wire

[dv/humidity_temperature_calibrate_tb.sv]
// Testbench for the humidity/temperature calibrator: random and directed samples, scoreboard.
`timescale 1ns / 1ps
module humidity_temperature_calibrate_tb;

  typedef struct {
    logic hv;
    logic signed [htc_pkg::VALUE_W-1:0] hval;
    logic hse;
    logic tv;
    logic signed [htc_pkg::VALUE_W-1:0] tval;
    logic tse;
  } cal_result_t;

  class cal_scoreboard;
    logic [15:0] regs [8];
    cal_result_t pending [$];
    int mismatches;

    function new();
      for (int i = 0; i < 8; i++) regs[i] = '0;
      mismatches = 0;
    endfunction

    // two-point interpolation for one lane, exact in 64 bits
    function void interp(input logic rdy, input logic signed [15:0] c,
                         input logic signed [15:0] r0, input logic signed [15:0] r1,
                         input longint p0, input longint p1, input int k,
                         output logic v, output logic signed [htc_pkg::VALUE_W-1:0] val,
                         output logic se);
      longint den, unit, q, res;
      v = 0; val = '0; se = 0;
      if (rdy) begin
        den = longint'(r1) - longint'(r0);
        if (den == 0) begin
          se = 1;
        end else begin
          unit = longint'(1) << (htc_pkg::FRACTION_BITS_DEF - k);
          q = ((longint'(c) - longint'(r0)) * (p1 - p0) * unit) / den;
          res = q + p0 * unit;
          if (res > 8388607) res = 8388607;
          if (res < -8388608) res = -8388608;
          v = 1;
          val = res[htc_pkg::VALUE_W-1:0];
        end
      end
    endfunction

    function void note_sample(logic hr, logic [15:0] hraw, logic tr, logic [15:0] traw);
      cal_result_t e;
      interp(hr, hraw, regs[htc_pkg::REG_HUM_R0], regs[htc_pkg::REG_HUM_R1],
             longint'(regs[htc_pkg::REG_HUM_P0][7:0]),
             longint'(regs[htc_pkg::REG_HUM_P1][7:0]), htc_pkg::HUM_SHIFT,
             e.hv, e.hval, e.hse);
      interp(tr, traw, regs[htc_pkg::REG_TEMP_R0], regs[htc_pkg::REG_TEMP_R1],
             longint'(regs[htc_pkg::REG_TEMP_P0][9:0]),
             longint'(regs[htc_pkg::REG_TEMP_P1][9:0]),
             htc_pkg::TEMP_SHIFT, e.tv, e.tval, e.tse);
      pending.push_back(e);
    endfunction

    function void check_result(cal_result_t a);
      cal_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      if (a.hv !== e.hv || a.hval !== e.hval || a.hse !== e.hse || a.tv !== e.tv ||
          a.tval !== e.tval || a.tse !== e.tse) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp h %b %0d %b t %b %0d %b, got h %b %0d %b t %b %0d %b",
                   e.hv, e.hval, e.hse, e.tv, e.tval, e.tse,
                   a.hv, a.hval, a.hse, a.tv, a.tval, a.tse);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [htc_pkg::CFG_W-1:0] cfg_data = '0;
  int send_idle_pct = 8, recv_idle_pct = 63;
  int hold_off = 0;
  longint cycles = 0;
  cal_scoreboard sb;

  htc_in_if  in_ch ();
  htc_out_if out_ch ();

  humidity_temperature_calibrate dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.humidity_ready = 0;
    in_ch.humidity_raw = '0;
    in_ch.temperature_ready = 0;
    in_ch.temperature_raw = '0;
    out_ch.ready = 0;
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cal_result_t a;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.hv = out_ch.humidity_valid;
      a.hval = out_ch.humidity_value;
      a.hse = out_ch.humidity_span_error;
      a.tv = out_ch.temperature_valid;
      a.tval = out_ch.temperature_value;
      a.tse = out_ch.temperature_span_error;
      sb.check_result(a);
    end
    if (cycles > 400000) begin
      $display("[humidity_temperature_calibrate] ERROR");
      $finish;
    end
  end

  task automatic write_reg(htc_pkg::cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.regs[idx] = val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_drained();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // offer one sample at falling edges until a transfer happens
  task automatic send_sample(logic hr, logic [15:0] hraw, logic tr, logic [15:0] traw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.humidity_ready <= hr;
    in_ch.humidity_raw <= hraw;
    in_ch.temperature_ready <= tr;
    in_ch.temperature_raw <= traw;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(hr, hraw, tr, traw);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_raw();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config();
    write_reg(htc_pkg::REG_HUM_P0, 16'($urandom_range(255)));
    write_reg(htc_pkg::REG_HUM_P1, 16'($urandom_range(255)));
    write_reg(htc_pkg::REG_TEMP_P0, 16'($urandom_range(1023)));
    write_reg(htc_pkg::REG_TEMP_P1, 16'($urandom_range(1023)));
    write_reg(htc_pkg::REG_HUM_R0, rnd_raw());
    write_reg(htc_pkg::REG_HUM_R1, ($urandom_range(9) == 0) ?
              sb.regs[htc_pkg::REG_HUM_R0] : rnd_raw());
    write_reg(htc_pkg::REG_TEMP_R0, rnd_raw());
    write_reg(htc_pkg::REG_TEMP_R1, ($urandom_range(9) == 0) ?
              sb.regs[htc_pkg::REG_TEMP_R0] : rnd_raw());
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++)
      send_sample($urandom_range(7) != 0, rnd_raw(), $urandom_range(7) != 0, rnd_raw());
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1;
    // reset registers: both spans are zero
    send_sample(1, 16'h1234, 1, 16'h8000);
    send_sample(0, 16'h7fff, 0, 16'hffff);
    wait_drained();
    // extreme config, wide spans and saturation
    write_reg(htc_pkg::REG_HUM_P0, 16'd0);
    write_reg(htc_pkg::REG_HUM_P1, 16'd255);
    write_reg(htc_pkg::REG_TEMP_P0, 16'd1023);
    write_reg(htc_pkg::REG_TEMP_P1, 16'd0);
    write_reg(htc_pkg::REG_HUM_R0, 16'h8000);
    write_reg(htc_pkg::REG_HUM_R1, 16'h8001);
    write_reg(htc_pkg::REG_TEMP_R0, 16'h7fff);
    write_reg(htc_pkg::REG_TEMP_R1, 16'h7ffe);
    send_sample(1, 16'h7fff, 1, 16'h8000);
    send_sample(1, 16'h8000, 1, 16'h7fff);
    send_sample(1, 16'h0000, 0, 16'h0000);
    send_sample(0, 16'hffff, 1, 16'hffff);
    send_sample(1, 16'h5555, 1, 16'haaaa);
    wait_drained();
    write_reg(htc_pkg::REG_HUM_R1, 16'h7fff);
    write_reg(htc_pkg::REG_TEMP_R1, 16'h8000);
    write_reg(htc_pkg::REG_HUM_P0, 16'd255);
    write_reg(htc_pkg::REG_HUM_P1, 16'd0);
    write_reg(htc_pkg::REG_TEMP_P0, 16'd0);
    write_reg(htc_pkg::REG_TEMP_P1, 16'd1023);
    send_sample(1, 16'h7fff, 1, 16'h7fff);
    send_sample(1, 16'h8000, 1, 16'h8000);
    send_sample(1, 16'h0001, 1, 16'hfffe);
    // long receiver stall while the sender keeps pushing
    hold_off = 300;
    random_run(60);
    wait_drained();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 63; recv_idle_pct = 8; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_config();
      random_run(115);
      wait_drained();
    end
    wait_drained();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[humidity_temperature_calibrate] OK");
    else
      $display("[humidity_temperature_calibrate] ERROR");
    $finish;
  end
endmodule

[filelist.f]
src/htc_pkg.sv
src/htc_if.sv
src/htc_div.sv
src/htc_lane.sv
src/humidity_temperature_calibrate.sv
dv/humidity_temperature_calibrate_tb.sv
